>>> rtl/dett_pkg.sv
// ----------------------------------------------------------------------------
// dett_pkg
// Shared types and codes for the delayed event timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dett_pkg;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_DELIVERED   = 3'd3,
    ST_NOTHING_DUE = 3'd4
  } status_e;

  localparam int unsigned IdW  = 16;
  localparam int unsigned DlyW = 24;
  localparam int unsigned TimW = 32;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // latch the input beat, restart the scan
    logic    clear_all;   // drop every slot
    logic    scan;        // issue the next slot read
    logic    write_slot;  // store the new event in the checked slot
    logic    free_slot;   // release the checked slot
    logic    pend_load;   // hold the checked slot's handle as pending delivery
    logic    emit;        // drive a result beat
    status_e emit_status;
    logic    emit_pend;   // result carries the pending handle
    logic    emit_last;
  } dett_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;       // latched command
    logic chk_vld;   // a slot is under check this cycle
    logic hit;       // checked slot matches the command
    logic chk_last;  // checked slot is the final one
    logic pend_vld;  // a delivery is held back
  } dett_stat_t;

endpackage

`default_nettype wire

>>> rtl/dett_datapath.sv
// ----------------------------------------------------------------------------
// dett_datapath
// Slot storage, scan pipeline, slot match logic and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dett_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  dett_pkg::dett_ctrl_t         ctrl_i,
  output dett_pkg::dett_stat_t         stat_o,
  input  wire  [1:0]                   command_i,
  input  wire  [dett_pkg::IdW-1:0]     event_id_i,
  input  wire  [dett_pkg::DlyW-1:0]    delay_ms_i,
  input  wire  [dett_pkg::TimW-1:0]    now_time_i,
  output logic                         result_valid_o,
  output logic [2:0]                   status_o,
  output logic [dett_pkg::IdW-1:0]     delivered_id_o,
  output logic                         last_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = IW + 1;

  // latched beat
  dett_pkg::cmd_e              cmd_q;
  logic [dett_pkg::IdW-1:0]    id_q;
  logic [dett_pkg::TimW-1:0]   now_q;
  logic [dett_pkg::TimW-1:0]   exp_q;

  logic [TABLE_DEPTH-1:0]      valid_q;
  logic [dett_pkg::IdW-1:0]    ev_mem_q [TABLE_DEPTH];
  logic [dett_pkg::TimW-1:0]   ex_mem_q [TABLE_DEPTH];
  logic [dett_pkg::IdW-1:0]    ev_rd_q;
  logic [dett_pkg::TimW-1:0]   ex_rd_q;

  logic [CW-1:0]               rd_cnt_q;
  logic [IW-1:0]               chk_idx_q;
  logic                        chk_vld_q;
  logic                        issue;

  logic                        pend_vld_q;
  logic [dett_pkg::IdW-1:0]    pend_id_q;

  logic                        res_vld_q;
  dett_pkg::status_e           res_status_q;
  logic [dett_pkg::IdW-1:0]    res_id_q;
  logic                        res_last_q;

  logic [dett_pkg::TimW:0]     exp_sum;
  logic [dett_pkg::TimW-1:0]   exp_sat;
  logic                        slot_vb;
  logic                        hit;

  // saturating expiry
  assign exp_sum = {1'b0, now_time_i}
                 + {{(dett_pkg::TimW + 1 - dett_pkg::DlyW){1'b0}}, delay_ms_i};
  assign exp_sat = exp_sum[dett_pkg::TimW] ? {dett_pkg::TimW{1'b1}}
                                           : exp_sum[dett_pkg::TimW-1:0];

  assign issue = ctrl_i.scan && (rd_cnt_q < CW'(TABLE_DEPTH));

  always_comb begin
    slot_vb = valid_q[chk_idx_q];
    unique case (cmd_q)
      dett_pkg::CMD_ENQ:   hit = !slot_vb;
      dett_pkg::CMD_DEQ:   hit = slot_vb && (ev_rd_q == id_q);
      dett_pkg::CMD_TICK:  hit = slot_vb && (ex_rd_q <= now_q);
      dett_pkg::CMD_CLEAR: hit = 1'b0;
      default:             hit = 1'b0;
    endcase
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.chk_vld  = chk_vld_q;
  assign stat_o.hit      = hit;
  assign stat_o.chk_last = (chk_idx_q == IW'(TABLE_DEPTH - 1));
  assign stat_o.pend_vld = pend_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= dett_pkg::cmd_e'(command_i);
      id_q  <= event_id_i;
      now_q <= now_time_i;
      exp_q <= exp_sat;
    end
  end

  // slot memories: one write and one read port, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_slot) begin
      ev_mem_q[chk_idx_q] <= id_q;
      ex_mem_q[chk_idx_q] <= exp_q;
    end
    if (issue) begin
      ev_rd_q <= ev_mem_q[rd_cnt_q[IW-1:0]];
      ex_rd_q <= ex_mem_q[rd_cnt_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      chk_idx_q <= rd_cnt_q[IW-1:0];
    end
    if (ctrl_i.pend_load) begin
      pend_id_q <= ev_rd_q;
    end
    if (ctrl_i.emit) begin
      res_status_q <= ctrl_i.emit_status;
      res_id_q     <= ctrl_i.emit_pend ? pend_id_q : '0;
      res_last_q   <= ctrl_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_cnt_q   <= '0;
      chk_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      chk_vld_q <= issue;
      res_vld_q <= ctrl_i.emit;
      if (ctrl_i.load) begin
        rd_cnt_q   <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        if (ctrl_i.pend_load) begin
          pend_vld_q <= 1'b1;
        end
      end
      if (ctrl_i.clear_all) begin
        valid_q <= '0;
      end else if (ctrl_i.write_slot) begin
        valid_q[chk_idx_q] <= 1'b1;
      end else if (ctrl_i.free_slot) begin
        valid_q[chk_idx_q] <= 1'b0;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign delivered_id_o = res_id_q;
  assign last_o         = res_last_q;

endmodule

`default_nettype wire

>>> rtl/dett_ctrl.sv
// ----------------------------------------------------------------------------
// dett_ctrl
// Command sequencer: clears the table or starts the slot scan, decides on each checked slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dett_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  input  wire  [1:0]            command_i,
  input  dett_pkg::dett_stat_t  stat_i,
  output dett_pkg::dett_ctrl_t  ctrl_o,
  output logic                  busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d            = state_q;
    ctrl_o             = '0;
    ctrl_o.emit_status = dett_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          if (dett_pkg::cmd_e'(command_i) == dett_pkg::CMD_CLEAR) begin
            ctrl_o.clear_all = 1'b1;
            state_d          = S_FINAL;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.chk_vld) begin
          unique case (stat_i.cmd)
            dett_pkg::CMD_ENQ: begin
              if (stat_i.hit) begin
                ctrl_o.write_slot = 1'b1;
                ctrl_o.emit       = 1'b1;
                ctrl_o.emit_last  = 1'b1;
                state_d           = S_IDLE;
              end else if (stat_i.chk_last) begin
                ctrl_o.emit        = 1'b1;
                ctrl_o.emit_status = dett_pkg::ST_FULL;
                ctrl_o.emit_last   = 1'b1;
                state_d            = S_IDLE;
              end
            end
            dett_pkg::CMD_DEQ: begin
              if (stat_i.hit) begin
                ctrl_o.free_slot = 1'b1;
                ctrl_o.emit      = 1'b1;
                ctrl_o.emit_last = 1'b1;
                state_d          = S_IDLE;
              end else if (stat_i.chk_last) begin
                ctrl_o.emit        = 1'b1;
                ctrl_o.emit_status = dett_pkg::ST_NOT_FOUND;
                ctrl_o.emit_last   = 1'b1;
                state_d            = S_IDLE;
              end
            end
            dett_pkg::CMD_TICK: begin
              // a due slot pushes out the one held before it
              if (stat_i.hit) begin
                ctrl_o.free_slot = 1'b1;
                ctrl_o.pend_load = 1'b1;
                if (stat_i.pend_vld) begin
                  ctrl_o.emit        = 1'b1;
                  ctrl_o.emit_status = dett_pkg::ST_DELIVERED;
                  ctrl_o.emit_pend   = 1'b1;
                end
              end
              if (stat_i.chk_last) begin
                state_d = S_FINAL;
              end
            end
            dett_pkg::CMD_CLEAR: begin
              state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FINAL: begin
        ctrl_o.emit      = 1'b1;
        ctrl_o.emit_last = 1'b1;
        if (stat_i.cmd == dett_pkg::CMD_TICK) begin
          ctrl_o.emit_status = stat_i.pend_vld ? dett_pkg::ST_DELIVERED
                                               : dett_pkg::ST_NOTHING_DUE;
          ctrl_o.emit_pend   = stat_i.pend_vld;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/delayed_event_timer_table.sv
// ----------------------------------------------------------------------------
// delayed_event_timer_table
// Table of pending events with expiry times: enqueue, dequeue, tick, clear.
// ----------------------------------------------------------------------------
// Clear drops every slot without a scan. Enqueue stops at the first free slot,
//   dequeue at the first slot that holds the handle; a miss scans every slot.
// Tick: scans every slot, one per cycle. A due event is held until the next due
//   slot is checked, else it is the final beat.
// Throughput: one item at a time, busy drops as the final beat goes out; the
//   receiver cannot stall. Reset: async, active low; empties the table, idle.
`timescale 1ns / 1ps
`default_nettype none

module delayed_event_timer_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire  [1:0]                command_i,
  input  wire  [dett_pkg::IdW-1:0]  event_id_i,
  input  wire  [dett_pkg::DlyW-1:0] delay_ms_i,
  input  wire  [dett_pkg::TimW-1:0] now_time_i,
  output logic                      result_valid_o,
  output logic [2:0]                status_o,
  output logic [dett_pkg::IdW-1:0]  delivered_id_o,
  output logic                      last_o
);

  dett_pkg::dett_ctrl_t ctrl;
  dett_pkg::dett_stat_t stat;

  // Sequencer: walks the slot scan and issues one decision per checked slot.
  dett_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy      (busy)
  );

  // Datapath: valid bits in flops, handle and expiry in slot memories,
  // a one-deep hold for the latest due event so its last flag is known
  // only once the scan has passed the final slot.
  dett_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (command_i),
    .event_id_i     (event_id_i),
    .delay_ms_i     (delay_ms_i),
    .now_time_i     (now_time_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .delivered_id_o (delivered_id_o),
    .last_o         (last_o)
  );

  // final beat of an item leaves the block idle
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("final beat while still busy");

  // an intermediate delivery is only seen mid-item
  a_mid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (busy && status_o == dett_pkg::ST_DELIVERED))
    else $error("non-final beat outside a tick");

  // handle is zero unless an event is delivered
  a_id_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != dett_pkg::ST_DELIVERED) |-> (delivered_id_o == '0))
    else $error("stray handle on a non-delivery beat");

  // an accepted beat always occupies the block
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

endmodule

`default_nettype wire
